@@ design/pnc_pkg.sv @@
`default_nettype none
package pnc_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = 9;
  localparam int DIST_W        = 18;

  localparam logic [9:0] WEIGHT_RED   = 10'd299;
  localparam logic [9:0] WEIGHT_GREEN = 10'd587;
  localparam logic [9:0] WEIGHT_BLUE  = 10'd114;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_FIND   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_RANGE     = 2'd2;

  localparam int          CFG_ADDR_W       = 3;
  localparam logic        REG_ENTRY_COUNT  = 1'b0;
  localparam logic [17:0] MAX_DISTANCE     = 18'd255000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } tag_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

@@ design/pnc_dist.sv @@
`default_nettype none
module pnc_dist (
  input  logic          clk,
  input  logic          rst,
  input  pnc_pkg::tag_t in_tag,
  input  pnc_pkg::rgb_t entry,
  input  pnc_pkg::rgb_t target,
  output pnc_pkg::tag_t out_tag,
  output pnc_pkg::rgb_t out_entry,
  output logic [17:0]   out_dist
);
  import pnc_pkg::*;

  // Stage one: weighted channel differences. Stage two: their sum.
  tag_t        tag1;
  rgb_t        entry1;
  logic [17:0] prod_r;
  logic [17:0] prod_g;
  logic [17:0] prod_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.valid    <= 1'b0;
      out_tag.valid <= 1'b0;
    end else begin
      tag1.valid    <= in_tag.valid;
      out_tag.valid <= tag1.valid;
    end
    tag1.idx    <= in_tag.idx;
    entry1      <= entry;
    prod_r      <= {8'd0, WEIGHT_RED}   * {10'd0, abs_diff(target.red,   entry.red)};
    prod_g      <= {8'd0, WEIGHT_GREEN} * {10'd0, abs_diff(target.green, entry.green)};
    prod_b      <= {8'd0, WEIGHT_BLUE}  * {10'd0, abs_diff(target.blue,  entry.blue)};
    out_tag.idx <= tag1.idx;
    out_entry   <= entry1;
    out_dist    <= prod_r + prod_g + prod_b;
  end

endmodule
`default_nettype wire

@@ design/palette_nearest_colour_top.sv @@
`default_nettype none
// Write: the result strobe follows in the cycle after acceptance; busy stays low.
// Read: the registered palette RAM read is returned as the result from ST_READ.
// Find: scans the N entries in use with one palette RAM read per cycle through the
// two-stage distance pipeline; busy holds off a new command until the result beat.
// Results cannot be stalled: done marks each beat for exactly one cycle.
// Synchronous active-high reset clears control and entry_count; palette RAM is not cleared.
module palette_nearest_colour_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        done,
  output logic [1:0]  status,
  output logic [7:0]  found_index,
  output logic [17:0] best_distance,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [pnc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pnc_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_SCAN} state_t;

  state_t           state;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] scan_count;
  logic [CNT_W-1:0] issue_ptr;
  rgb_t             target;
  tag_t             mem_tag;
  logic             accept;

  // Palette RAM: one write port, one registered read port.
  rgb_t             palette_mem [PALETTE_DEPTH];
  logic [IDX_W-1:0] rd_addr;
  rgb_t             rd_data;
  logic             wr_en;

  // Distance pipeline outputs and best-so-far tracking.
  tag_t             d_tag;
  rgb_t             d_entry;
  logic [17:0]      d_dist;
  logic             have_best;
  logic [IDX_W-1:0] best_idx;
  logic [17:0]      best_dist;
  rgb_t             best_entry;
  logic             take;
  logic             last_beat;
  logic [IDX_W-1:0] win_idx;
  logic [17:0]      win_dist;
  rgb_t             win_entry;

  // ---------------------------------------------------------------------------
  // Configuration port: one register, entry_count, at byte address 0.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? {23'd0, entry_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENTRY_COUNT) begin
      entry_count <= pwdata[CNT_W-1:0];
    end
  end

  // Clamp the count to the RAM depth.
  assign n_eff  = (entry_count > CNT_W'(PALETTE_DEPTH)) ? CNT_W'(PALETTE_DEPTH) : entry_count;
  assign accept = start && !busy;
  assign wr_en  = accept && cmd == CMD_WRITE;

  // ---------------------------------------------------------------------------
  // Palette RAM. Writes only land while idle, so a later read never races one.
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (state)
      ST_IDLE: rd_addr = (cmd == CMD_READ) ? entry_index : '0;
      ST_SCAN: rd_addr = issue_ptr[IDX_W-1:0];
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      palette_mem[entry_index] <= '{red: red_in, green: green_in, blue: blue_in};
    end
    rd_data <= palette_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // Weighted L1 distance of each scanned entry, registered in pnc_dist from the read data.
  // ---------------------------------------------------------------------------
  pnc_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_tag    (mem_tag),
    .entry     (rd_data),
    .target    (target),
    .out_tag   (d_tag),
    .out_entry (d_entry),
    .out_dist  (d_dist)
  );

  // Replace only on a strictly smaller distance so the lowest index wins ties.
  assign take      = !have_best || d_dist < best_dist;
  assign last_beat = d_tag.valid && ({1'b0, d_tag.idx} == scan_count - 1'b1);
  assign win_idx   = take ? d_tag.idx : best_idx;
  assign win_dist  = take ? d_dist    : best_dist;
  assign win_entry = take ? d_entry   : best_entry;

  // ---------------------------------------------------------------------------
  // Sequencer: state, busy and the result beat.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      busy          <= 1'b0;
      done          <= 1'b0;
      have_best     <= 1'b0;
      mem_tag.valid <= 1'b0;
    end else begin
      done          <= 1'b0;
      mem_tag.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            // Clear the result beat; each arm fills what it owns.
            status        <= STATUS_OK;
            found_index   <= '0;
            best_distance <= '0;
            red_out       <= '0;
            green_out     <= '0;
            blue_out      <= '0;
            target        <= '{red: red_in, green: green_in, blue: blue_in};
            scan_count    <= n_eff;
            unique case (cmd)
              CMD_WRITE: begin
                done <= 1'b1;
              end
              CMD_READ: begin
                if ({1'b0, entry_index} >= n_eff) begin
                  status <= STATUS_RANGE;
                  done   <= 1'b1;
                end else begin
                  state <= ST_READ;
                  busy  <= 1'b1;
                end
              end
              CMD_FIND: begin
                if (n_eff == '0) begin
                  status <= STATUS_NOT_FOUND;
                  done   <= 1'b1;
                end else begin
                  // Entry 0 is read on this edge; continue from entry 1.
                  mem_tag.valid <= 1'b1;
                  mem_tag.idx   <= '0;
                  issue_ptr     <= CNT_W'(1);
                  have_best     <= 1'b0;
                  state         <= ST_SCAN;
                  busy          <= 1'b1;
                end
              end
              default: begin
                // Unused command: drop the beat.
              end
            endcase
          end
        end
        ST_READ: begin
          red_out   <= rd_data.red;
          green_out <= rd_data.green;
          blue_out  <= rd_data.blue;
          done      <= 1'b1;
          state     <= ST_IDLE;
          busy      <= 1'b0;
        end
        ST_SCAN: begin
          // Advance the read pointer until every entry in use is issued.
          if (issue_ptr < scan_count) begin
            mem_tag.valid <= 1'b1;
            mem_tag.idx   <= issue_ptr[IDX_W-1:0];
            issue_ptr     <= issue_ptr + 1'b1;
          end
          if (d_tag.valid) begin
            have_best  <= 1'b1;
            best_idx   <= win_idx;
            best_dist  <= win_dist;
            best_entry <= win_entry;
          end
          if (last_beat) begin
            found_index   <= win_idx;
            best_distance <= win_dist;
            red_out       <= win_entry.red;
            green_out     <= win_entry.green;
            blue_out      <= win_entry.blue;
            done          <= 1'b1;
            have_best     <= 1'b0;
            state         <= ST_IDLE;
            busy          <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/pnc_checker.sv @@
`default_nettype none
module pnc_protocol_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  cmd,
  input logic        done,
  input logic [1:0]  status,
  input logic [7:0]  found_index,
  input logic [17:0] best_distance,
  input logic [7:0]  red_out,
  input logic [7:0]  green_out,
  input logic [7:0]  blue_out
);
  import pnc_pkg::*;

  // A write always answers on the next cycle with status ok.
  a_write_beat: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd == CMD_WRITE |=> done && status == STATUS_OK)
    else $error("write beat missing or not ok");

  // An unused command gives no result beat.
  a_unused_drop: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd == CMD_UNUSED |=> !done)
    else $error("unused command produced a beat");

  // No result beat while the block still reports busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    !(done && busy))
    else $error("done asserted while busy");

  // Error beats carry zero payload.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != STATUS_OK |-> found_index == 8'd0 && best_distance == 18'd0
      && red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0)
    else $error("error beat with nonzero payload");

  // Weighted distance never exceeds the full-scale value.
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    done |-> best_distance <= MAX_DISTANCE)
    else $error("distance out of range");

endmodule

bind palette_nearest_colour_top pnc_protocol_checker u_pnc_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .cmd           (cmd),
  .done          (done),
  .status        (status),
  .found_index   (found_index),
  .best_distance (best_distance),
  .red_out       (red_out),
  .green_out     (green_out),
  .blue_out      (blue_out)
);
`default_nettype wire
